// ===== rtl/qsv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qsv_pkg
// Shared constants, types and helper functions of the state-vector engine.
// ----------------------------------------------------------------------------
package qsv_pkg;

    localparam int MAX_QUBITS   = 10;
    localparam int COMP_W       = 18;
    localparam int MAX_READ     = 64;
    localparam int DIM_MAX      = 1 << MAX_QUBITS;
    localparam int ADDR_W       = MAX_QUBITS;
    localparam int CNT_W        = ADDR_W + 1;
    localparam int PW_W         = 2 * COMP_W;
    localparam int SUM_W        = PW_W + 2;
    localparam int ACC_W        = PW_W + MAX_QUBITS;
    localparam int Q_ONE        = 65536;
    localparam int H_COEF       = 46341;
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_X0    = 10188013;
    localparam int CX_W         = 28;
    localparam int CZ_W         = 19;

    localparam logic [3:0] F_RESET  = 4'd0;
    localparam logic [3:0] F_H      = 4'd1;
    localparam logic [3:0] F_X      = 4'd2;
    localparam logic [3:0] F_RX     = 4'd3;
    localparam logic [3:0] F_RY     = 4'd4;
    localparam logic [3:0] F_RZ     = 4'd5;
    localparam logic [3:0] F_CNOT   = 4'd6;
    localparam logic [3:0] F_READ   = 4'd7;
    localparam logic [3:0] F_SAMPLE = 4'd8;

    typedef enum logic [1:0] {
        KIND_GATE   = 2'd0,
        KIND_IGNORE = 2'd1,
        KIND_PROB   = 2'd2,
        KIND_SAMPLE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_IGNORE,
        OP_GATE,
        OP_ROT,
        OP_READ,
        OP_SAMPLE
    } t_op;

    typedef struct packed {
        logic       ld;
        logic       idx_zero;
        logic       idx_off;
        logic       idx_inc;
        logic       clr_wr;
        logic       rd_pair;
        logic       rd_one;
        logic       mul_en;
        logic       acc_en;
        logic       prob;
        logic [1:0] k;
        logic       wr0;
        logic       wr1;
        logic       smp_clr;
        logic       smp_acc;
        logic       trig_go;
        logic       mat_ld;
        logic       out_load;
        t_kind      out_kind;
        logic       out_last;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic clr_last;
        logic pair_last;
        logic read_last;
        logic smp_hit;
        logic smp_end;
        logic out_free;
        logic trig_done;
    } t_stat;

    function automatic logic [15:0] cordic_atan(input logic [3:0] i);
        logic [15:0] v;
        case (i)
            4'd0:    v = 16'd32768;
            4'd1:    v = 16'd19344;
            4'd2:    v = 16'd10221;
            4'd3:    v = 16'd5188;
            4'd4:    v = 16'd2604;
            4'd5:    v = 16'd1303;
            4'd6:    v = 16'd652;
            4'd7:    v = 16'd326;
            4'd8:    v = 16'd163;
            4'd9:    v = 16'd81;
            4'd10:   v = 16'd41;
            4'd11:   v = 16'd20;
            4'd12:   v = 16'd10;
            4'd13:   v = 16'd5;
            4'd14:   v = 16'd3;
            default: v = 16'd1;
        endcase
        return v;
    endfunction

    // |amp|^2 rounded half up to Q1.16, saturated at one
    function automatic logic [16:0] prob_word(input logic [PW_W-1:0] pw);
        logic [PW_W-16:0] v;
        v = (PW_W-15)'(pw[PW_W-1:16]) + (PW_W-15)'(pw[15]);
        if (v > (PW_W-15)'(Q_ONE)) begin
            return 17'(Q_ONE);
        end
        return v[16:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/qsv_cordic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qsv_cordic
// Iterative 16-step CORDIC giving cos and sin of a half-angle in Q1.16.
// ----------------------------------------------------------------------------
module qsv_cordic import qsv_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_go,
    input  logic [17:0]              i_angle,
    output logic                     o_done,
    output logic signed [COMP_W-1:0] o_cos,
    output logic signed [COMP_W-1:0] o_sin
);

    logic signed [CX_W-1:0] r_x, r_y;
    logic signed [CZ_W-1:0] r_z;
    logic [3:0]             r_i;
    logic [1:0]             r_q;
    logic                   r_busy, r_done;

    logic signed [CX_W-1:0]   dx, dy, xr, yr;
    logic signed [CZ_W-1:0]   at;
    logic signed [COMP_W-1:0] c, s;

    assign dx = r_y >>> r_i;
    assign dy = r_x >>> r_i;
    assign at = CZ_W'(cordic_atan(r_i));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_i == 4'(CORDIC_STEPS - 1));
            if (i_go) begin
                r_busy <= 1'b1;
            end else if (r_i == 4'(CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
        if (i_go) begin
            r_x <= CX_W'(CORDIC_X0);
            r_y <= '0;
            r_z <= CZ_W'(i_angle[15:0]);
            r_q <= i_angle[17:16];
            r_i <= '0;
        end else if (r_busy) begin
            r_i <= r_i + 4'd1;
            if (!r_z[CZ_W-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
        end
    end

    assign xr = (r_x + CX_W'(128)) >>> 8;
    assign yr = (r_y + CX_W'(128)) >>> 8;

    always_comb begin
        if (xr > CX_W'(Q_ONE)) c = COMP_W'(Q_ONE);
        else if (xr < -CX_W'(Q_ONE)) c = -COMP_W'(Q_ONE);
        else c = xr[COMP_W-1:0];
        if (yr > CX_W'(Q_ONE)) s = COMP_W'(Q_ONE);
        else if (yr < -CX_W'(Q_ONE)) s = -COMP_W'(Q_ONE);
        else s = yr[COMP_W-1:0];
        case (r_q)
            2'd0:    begin o_cos = c;  o_sin = s;  end
            2'd1:    begin o_cos = -s; o_sin = c;  end
            2'd2:    begin o_cos = -c; o_sin = -s; end
            default: begin o_cos = s;  o_sin = -c; end
        endcase
    end

    assign o_done = r_done;

endmodule
`default_nettype wire

// ===== rtl/qsv_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qsv_dp
// Datapath: amplitude store, pair addressing, 4-way multiply bank,
// round/saturate, CDF accumulator, config register and output register.
// ----------------------------------------------------------------------------
module qsv_dp import qsv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data,
    input  logic [3:0]  i_func,
    input  logic [3:0]  i_target_qubit,
    input  logic [3:0]  i_control_qubit,
    input  logic [17:0] i_angle,
    input  logic [9:0]  i_read_offset,
    input  logic [6:0]  i_read_count,
    input  logic [15:0] i_uniform_draw,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [16:0] o_probability,
    output logic [9:0]  o_basis_index,
    output logic        o_last
);

    localparam int CMAX = (1 << (COMP_W - 1)) - 1;

    logic [3:0]        r_qubit_count;
    logic [3:0]        r_func, r_tq, r_cq;
    logic [17:0]       r_angle;
    logic [9:0]        r_off;
    logic [6:0]        r_cnt;
    logic [15:0]       r_draw;
    logic [ADDR_W-1:0] r_idx, r_last_idx;

    logic [2*COMP_W-1:0]      r_mem [DIM_MAX];
    logic [2*COMP_W-1:0]      r_rd0, r_rd1;
    logic signed [COMP_W-1:0] r_m [8];
    logic signed [PW_W-1:0]   r_prod [4];
    logic signed [COMP_W-1:0] r_res [4];
    logic [PW_W-1:0]          r_pw;
    logic [ACC_W-1:0]         r_acc;

    logic        r_out_valid, r_out_last;
    t_kind       r_out_kind;
    logic [16:0] r_out_prob;
    logic [9:0]  r_out_idx;

    logic [3:0]        q_used;
    logic [CNT_W-1:0]  dim_sz, off_c, rem, cnt_m, cnt_c;
    logic [ADDR_W-1:0] lmask, i0, i1, i0_sh, wa;
    logic [2*COMP_W-1:0] wd;
    logic              cbit, tq_bad, cx_bad;
    t_op               op;

    logic signed [COMP_W-1:0] trig_c, trig_s;
    logic                     trig_done;
    logic signed [COMP_W-1:0] m_eff [8];
    logic signed [COMP_W-1:0] mc [4], mo [4];
    logic signed [COMP_W-1:0] ar, ai, br, bi;
    logic signed [SUM_W-1:0]  sum_p, rnd, shv, c_hi, c_lo;
    logic signed [COMP_W-1:0] sat_v;
    logic [ACC_W-1:0]         acc_nx;

    qsv_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.trig_go),
        .i_angle (r_angle),
        .o_done  (trig_done),
        .o_cos   (trig_c),
        .o_sin   (trig_s)
    );

    // ---- sizes and decode
    always_comb begin
        if (r_qubit_count == 4'd0) q_used = 4'd1;
        else if (r_qubit_count > 4'(MAX_QUBITS)) q_used = 4'(MAX_QUBITS);
        else q_used = r_qubit_count;
        dim_sz = CNT_W'(1) << q_used;
        off_c  = (CNT_W'(r_off) > dim_sz) ? dim_sz : CNT_W'(r_off);
        rem    = dim_sz - off_c;
        cnt_m  = (r_cnt > 7'(MAX_READ)) ? CNT_W'(MAX_READ) : CNT_W'(r_cnt);
        cnt_c  = (cnt_m > rem) ? rem : cnt_m;
        tq_bad = r_tq >= q_used;
        cx_bad = tq_bad || (r_cq >= q_used) || (r_cq == r_tq);
        case (r_func)
            F_RESET:        op = OP_CLEAR;
            F_H, F_X:       op = tq_bad ? OP_IGNORE : OP_GATE;
            F_RX, F_RY, F_RZ: op = tq_bad ? OP_IGNORE : OP_ROT;
            F_CNOT:         op = cx_bad ? OP_IGNORE : OP_GATE;
            F_READ:         op = (cnt_c == '0) ? OP_IGNORE : OP_READ;
            F_SAMPLE:       op = OP_SAMPLE;
            default:        op = OP_IGNORE;
        endcase
    end

    // ---- pair addressing
    assign lmask = (ADDR_W'(1) << r_tq) - ADDR_W'(1);
    assign i0    = ((r_idx & ~lmask) << 1) | (r_idx & lmask);
    assign i1    = i0 | (ADDR_W'(1) << r_tq);
    assign i0_sh = i0 >> r_cq;
    assign cbit  = i0_sh[0];

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            m_eff[j] = r_m[j];
        end
        if (r_func == F_CNOT && !cbit) begin
            for (int j = 0; j < 8; j++) begin
                m_eff[j] = '0;
            end
            m_eff[0] = COMP_W'(Q_ONE);
            m_eff[6] = COMP_W'(Q_ONE);
        end
    end

    // ---- multiply operand select
    assign ar = r_rd0[2*COMP_W-1:COMP_W];
    assign ai = r_rd0[COMP_W-1:0];
    assign br = r_rd1[2*COMP_W-1:COMP_W];
    assign bi = r_rd1[COMP_W-1:0];

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            mc[j] = m_eff[{i_cmd.k[1], 2'(j)}];
        end
        if (i_cmd.prob) begin
            mc[0] = ar; mo[0] = ar;
            mc[1] = ai; mo[1] = ai;
            mc[2] = '0; mo[2] = '0;
            mc[3] = '0; mo[3] = '0;
        end else if (!i_cmd.k[0]) begin
            mc[1] = -mc[1];
            mc[3] = -mc[3];
            mo[0] = ar; mo[1] = ai; mo[2] = br; mo[3] = bi;
        end else begin
            mo[0] = ai; mo[1] = ar; mo[2] = bi; mo[3] = br;
        end
    end

    // ---- sum, round half up, saturate
    always_comb begin
        sum_p = SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]) + SUM_W'(r_prod[2])
              + SUM_W'(r_prod[3]);
        rnd   = sum_p + SUM_W'(32768);
        shv   = rnd >>> 16;
        c_hi  = SUM_W'(CMAX);
        c_lo  = -c_hi - SUM_W'(1);
        if (shv > c_hi) sat_v = COMP_W'(CMAX);
        else if (shv < c_lo) sat_v = c_lo[COMP_W-1:0];
        else sat_v = shv[COMP_W-1:0];
        acc_nx = r_acc + ACC_W'(r_pw);
    end

    // ---- memory write port
    always_comb begin
        wa = r_idx;
        wd = '0;
        if (i_cmd.clr_wr) begin
            wa = r_idx;
            wd = (r_idx == '0) ? {COMP_W'(Q_ONE), COMP_W'(0)} : '0;
        end else if (i_cmd.wr0) begin
            wa = i0;
            wd = {r_res[0], r_res[1]};
        end else if (i_cmd.wr1) begin
            wa = i1;
            wd = {r_res[2], r_res[3]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr || i_cmd.wr0 || i_cmd.wr1) begin
            r_mem[wa] <= wd;
        end
        if (i_cmd.rd_pair) begin
            r_rd0 <= r_mem[i0];
            r_rd1 <= r_mem[i1];
        end else if (i_cmd.rd_one) begin
            r_rd0 <= r_mem[r_idx];
        end
    end

    // ---- control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qubit_count <= 4'(MAX_QUBITS);
            r_idx         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_qubit_count <= i_cfg_data;
            end
            if (i_cmd.idx_zero) begin
                r_idx <= '0;
            end else if (i_cmd.idx_off) begin
                r_idx <= off_c[ADDR_W-1:0];
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + ADDR_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---- payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld) begin
            r_func  <= i_func;
            r_tq    <= i_target_qubit;
            r_cq    <= i_control_qubit;
            r_angle <= i_angle;
            r_off   <= i_read_offset;
            r_cnt   <= i_read_count;
            r_draw  <= i_uniform_draw;
        end
        if (i_cmd.idx_off) begin
            r_last_idx <= ADDR_W'(off_c + cnt_c - CNT_W'(1));
        end
        if (i_cmd.mat_ld) begin
            for (int j = 0; j < 8; j++) begin
                r_m[j] <= '0;
            end
            case (r_func)
                F_H: begin
                    r_m[0] <= COMP_W'(H_COEF);
                    r_m[2] <= COMP_W'(H_COEF);
                    r_m[4] <= COMP_W'(H_COEF);
                    r_m[6] <= -COMP_W'(H_COEF);
                end
                F_RX: begin
                    r_m[0] <= trig_c;
                    r_m[3] <= -trig_s;
                    r_m[5] <= -trig_s;
                    r_m[6] <= trig_c;
                end
                F_RY: begin
                    r_m[0] <= trig_c;
                    r_m[2] <= -trig_s;
                    r_m[4] <= trig_s;
                    r_m[6] <= trig_c;
                end
                F_RZ: begin
                    r_m[0] <= trig_c;
                    r_m[1] <= -trig_s;
                    r_m[6] <= trig_c;
                    r_m[7] <= trig_s;
                end
                default: begin
                    r_m[2] <= COMP_W'(Q_ONE);
                    r_m[4] <= COMP_W'(Q_ONE);
                end
            endcase
        end
        if (i_cmd.mul_en) begin
            for (int j = 0; j < 4; j++) begin
                r_prod[j] <= mc[j] * mo[j];
            end
        end
        if (i_cmd.acc_en) begin
            if (i_cmd.prob) begin
                r_pw <= sum_p[PW_W-1:0];
            end else begin
                r_res[i_cmd.k] <= sat_v;
            end
        end
        if (i_cmd.smp_clr) begin
            r_acc <= '0;
        end else if (i_cmd.smp_acc) begin
            r_acc <= acc_nx;
        end
        if (i_cmd.out_load) begin
            r_out_kind <= i_cmd.out_kind;
            r_out_last <= i_cmd.out_last;
            if (i_cmd.out_kind == KIND_PROB || i_cmd.out_kind == KIND_SAMPLE) begin
                r_out_prob <= prob_word(r_pw);
                r_out_idx  <= r_idx;
            end else begin
                r_out_prob <= '0;
                r_out_idx  <= '0;
            end
        end
    end

    // ---- status
    always_comb begin
        o_stat.op        = op;
        o_stat.clr_last  = r_idx == ADDR_W'(DIM_MAX - 1);
        o_stat.pair_last = CNT_W'(r_idx) == ((dim_sz >> 1) - CNT_W'(1));
        o_stat.read_last = r_idx == r_last_idx;
        o_stat.smp_hit   = ACC_W'({r_draw, 16'd0}) < acc_nx;
        o_stat.smp_end   = CNT_W'(r_idx) == (dim_sz - CNT_W'(1));
        o_stat.out_free  = !r_out_valid || !i_out_stall;
        o_stat.trig_done = trig_done;
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_probability = r_out_prob;
    assign o_basis_index = r_out_idx;
    assign o_last        = r_out_last;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a pending transaction");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("loaded result not presented");

    a_pair_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr0 || i_cmd.wr1) |-> (CNT_W'(i1) < dim_sz && CNT_W'(i0) < dim_sz))
        else $error("gate write outside active state");

endmodule
`default_nettype wire

// ===== rtl/qsv_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qsv_ctrl
// Command sequencer: clear sweep, gate pair loop, probability read and
// sample scan, result hand-off.
// ----------------------------------------------------------------------------
module qsv_ctrl import qsv_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DEC, S_TRIG,
        S_G_RD, S_G_MUL, S_G_ACC, S_G_WR0, S_G_WR1,
        S_P_RD, S_P_MUL, S_P_ACC, S_P_OUT, S_EMIT
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_k, n_k;
    t_kind      r_ekind, n_ekind;
    logic       r_clr_cmd, n_clr_cmd;
    logic       r_smp, n_smp;

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_ekind   = r_ekind;
        n_clr_cmd = r_clr_cmd;
        n_smp     = r_smp;
        o_cmd     = '0;
        o_cmd.k   = r_k;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_wr  = 1'b1;
                o_cmd.idx_inc = 1'b1;
                if (i_stat.clr_last) begin
                    n_ekind = KIND_GATE;
                    n_state = r_clr_cmd ? S_EMIT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.ld = 1'b1;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                case (i_stat.op)
                    OP_CLEAR: begin
                        o_cmd.idx_zero = 1'b1;
                        n_clr_cmd      = 1'b1;
                        n_state        = S_CLR;
                    end
                    OP_GATE: begin
                        o_cmd.mat_ld   = 1'b1;
                        o_cmd.idx_zero = 1'b1;
                        n_state        = S_G_RD;
                    end
                    OP_ROT: begin
                        o_cmd.trig_go = 1'b1;
                        n_state       = S_TRIG;
                    end
                    OP_READ: begin
                        o_cmd.idx_off = 1'b1;
                        n_smp         = 1'b0;
                        n_state       = S_P_RD;
                    end
                    OP_SAMPLE: begin
                        o_cmd.idx_zero = 1'b1;
                        o_cmd.smp_clr  = 1'b1;
                        n_smp          = 1'b1;
                        n_state        = S_P_RD;
                    end
                    default: begin
                        n_ekind = KIND_IGNORE;
                        n_state = S_EMIT;
                    end
                endcase
            end
            S_TRIG: begin
                if (i_stat.trig_done) begin
                    o_cmd.mat_ld   = 1'b1;
                    o_cmd.idx_zero = 1'b1;
                    n_state        = S_G_RD;
                end
            end
            S_G_RD: begin
                o_cmd.rd_pair = 1'b1;
                n_k           = 2'd0;
                n_state       = S_G_MUL;
            end
            S_G_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_G_ACC;
            end
            S_G_ACC: begin
                o_cmd.acc_en = 1'b1;
                n_k          = r_k + 2'd1;
                n_state      = (r_k == 2'd3) ? S_G_WR0 : S_G_MUL;
            end
            S_G_WR0: begin
                o_cmd.wr0 = 1'b1;
                n_state   = S_G_WR1;
            end
            S_G_WR1: begin
                o_cmd.wr1 = 1'b1;
                if (i_stat.pair_last) begin
                    n_ekind = KIND_GATE;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_G_RD;
                end
            end
            S_P_RD: begin
                o_cmd.rd_one = 1'b1;
                n_state      = S_P_MUL;
            end
            S_P_MUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.prob   = 1'b1;
                n_state      = S_P_ACC;
            end
            S_P_ACC: begin
                o_cmd.acc_en = 1'b1;
                o_cmd.prob   = 1'b1;
                n_state      = S_P_OUT;
            end
            S_P_OUT: begin
                if (!r_smp) begin
                    if (i_stat.out_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_kind = KIND_PROB;
                        o_cmd.out_last = i_stat.read_last;
                        if (i_stat.read_last) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.idx_inc = 1'b1;
                            n_state       = S_P_RD;
                        end
                    end
                end else if (i_stat.smp_hit || i_stat.smp_end) begin
                    if (i_stat.out_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_kind = KIND_SAMPLE;
                        o_cmd.out_last = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.smp_acc = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_P_RD;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = r_ekind;
                    o_cmd.out_last = 1'b1;
                    n_clr_cmd      = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_k       <= '0;
            r_ekind   <= KIND_GATE;
            r_clr_cmd <= 1'b0;
            r_smp     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_ekind   <= n_ekind;
            r_clr_cmd <= n_clr_cmd;
            r_smp     <= n_smp;
        end
    end

    assign o_in_stall = r_state != S_IDLE;

endmodule
`default_nettype wire

// ===== rtl/qubit_state_vector_gate_engine_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qubit_state_vector_gate_engine_unit
// State-vector gate engine over a 1024-entry complex amplitude store.
// ----------------------------------------------------------------------------
// Gates: H/X/CNOT sweep the active state one amplitude pair at a time;
//   Rx/Ry/Rz first run the CORDIC; the reset command clears all 1024 entries.
// Read: one probability word per entry; sample: scans entries in order.
// One command in flight; the output register frees the input side at once.
// Pace is set by the single-write-port amplitude memory and the shared
//   4-multiplier bank. After reset a clearing pass over all 1024 entries runs first.
module qubit_state_vector_gate_engine_unit import qsv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_func,
    input  logic [3:0]  i_target_qubit,
    input  logic [3:0]  i_control_qubit,
    input  logic [17:0] i_angle,
    input  logic [9:0]  i_read_offset,
    input  logic [6:0]  i_read_count,
    input  logic [15:0] i_uniform_draw,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [16:0] o_probability,
    output logic [9:0]  o_basis_index,
    output logic        o_last
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    qsv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    qsv_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_func          (i_func),
        .i_target_qubit  (i_target_qubit),
        .i_control_qubit (i_control_qubit),
        .i_angle         (i_angle),
        .i_read_offset   (i_read_offset),
        .i_read_count    (i_read_count),
        .i_uniform_draw  (i_uniform_draw),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_probability   (o_probability),
        .o_basis_index   (o_basis_index),
        .o_last          (o_last)
    );

endmodule
`default_nettype wire

// ===== tb/tb_qubit_state_vector_gate_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// State-vector gate engine testbench
// Drives gate, read and sample commands through the valid/stall channel,
// predicts every result with a fixed-point amplitude model kept in the
// bench, and compares each result transaction field by field in order.
// ----------------------------------------------------------------------------
module tb_qubit_state_vector_gate_engine_unit;
    import qsv_pkg::*;

    typedef struct packed {
        t_kind       kind;
        logic [16:0] prob;
        logic [9:0]  idx;
        logic        last;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [3:0]  i_func = '0;
    logic [3:0]  i_target_qubit = '0;
    logic [3:0]  i_control_qubit = '0;
    logic [17:0] i_angle = '0;
    logic [9:0]  i_read_offset = '0;
    logic [6:0]  i_read_count = '0;
    logic [15:0] i_uniform_draw = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [16:0] o_probability;
    logic [9:0]  o_basis_index;
    logic        o_last;

    qubit_state_vector_gate_engine_unit dut (.*);

    always #1 i_clk = ~i_clk;

    longint amp_re [DIM_MAX];
    longint amp_im [DIM_MAX];
    int     nq;
    t_res   pending_results [$];
    int     mismatches = 0;
    longint cycles = 0;
    int     hold_cycles = 0;
    int     stall_mode = 0;
    int     burst_left = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd40_000_000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver stall pattern plus a long hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            default: i_out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    always @(posedge i_clk) begin
        t_res got, exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{t_kind'(o_kind), o_probability, o_basis_index, o_last};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                exp_r = pending_results.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10) $display("expected %p got %p", exp_r, got);
                end
            end
        end
    end

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd_sat(longint sum);
        longint v;
        v = asr(sum + 32768, 16);
        if (v > 131071) v = 131071;
        if (v < -131072) v = -131072;
        return v;
    endfunction

    function automatic longint lim1(longint v);
        return v > Q_ONE ? Q_ONE : (v < -Q_ONE ? -Q_ONE : v);
    endfunction

    function automatic void half_angle_trig(logic [17:0] ang, output longint co,
                                            output longint si);
        longint x, y, z, dx, dy, c, s;
        x = CORDIC_X0; y = 0; z = ang[15:0];
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = asr(y, i); dy = asr(x, i);
            if (z >= 0) begin x -= dx; y += dy; z -= cordic_atan(i[3:0]); end
            else begin x += dx; y -= dy; z += cordic_atan(i[3:0]); end
        end
        c = lim1(asr(x + 128, 8)); s = lim1(asr(y + 128, 8));
        case (ang[17:16])
            2'd0: begin co = c;  si = s;  end
            2'd1: begin co = -s; si = c;  end
            2'd2: begin co = -c; si = -s; end
            default: begin co = s; si = -c; end
        endcase
    endfunction

    function automatic longint power_at(int i);
        return amp_re[i] * amp_re[i] + amp_im[i] * amp_im[i];
    endfunction

    function automatic logic [16:0] prob_of(longint pw);
        longint v;
        v = (pw >> 16) + ((pw >> 15) & 1);
        return v > Q_ONE ? 17'(Q_ONE) : 17'(v);
    endfunction

    function automatic void clear_amplitudes();
        for (int i = 0; i < DIM_MAX; i++) begin amp_re[i] = 0; amp_im[i] = 0; end
        amp_re[0] = Q_ONE;
    endfunction

    function automatic void push_res(t_kind k, logic [16:0] p, int idx, bit l);
        t_res r;
        r = '{k, p, 10'(idx), l};
        pending_results.push_back(r);
    endfunction

    function automatic void predict_command(logic [3:0] fn, int tq, int cq,
                                            logic [17:0] ang, int off, int cnt, int r);
        int n, dim, i0, i1;
        longint m [8];
        longint co, si, ar, ai, br, bi, t, acc, thr;
        int pick;
        n = nq < 1 ? 1 : (nq > MAX_QUBITS ? MAX_QUBITS : nq);
        dim = 1 << n;
        if (fn == F_RESET) begin
            clear_amplitudes();
            push_res(KIND_GATE, 0, 0, 1);
        end else if (fn >= F_H && fn <= F_RZ) begin
            if (tq >= n) begin push_res(KIND_IGNORE, 0, 0, 1); return; end
            for (int k = 0; k < 8; k++) m[k] = 0;
            if (fn == F_H) begin
                m[0] = H_COEF; m[2] = H_COEF; m[4] = H_COEF; m[6] = -H_COEF;
            end else if (fn == F_X) begin
                m[2] = Q_ONE; m[4] = Q_ONE;
            end else begin
                half_angle_trig(ang, co, si);
                if (fn == F_RX) begin m[0] = co; m[3] = -si; m[5] = -si; m[6] = co; end
                else if (fn == F_RY) begin m[0] = co; m[2] = -si; m[4] = si; m[6] = co; end
                else begin m[0] = co; m[1] = -si; m[6] = co; m[7] = si; end
            end
            for (int p = 0; p < dim / 2; p++) begin
                i0 = ((p >> tq) << (tq + 1)) | (p & ((1 << tq) - 1));
                i1 = i0 | (1 << tq);
                ar = amp_re[i0]; ai = amp_im[i0]; br = amp_re[i1]; bi = amp_im[i1];
                if (fn == F_X) begin
                    amp_re[i0] = br; amp_im[i0] = bi; amp_re[i1] = ar; amp_im[i1] = ai;
                end else begin
                    amp_re[i0] = rnd_sat(m[0]*ar - m[1]*ai + m[2]*br - m[3]*bi);
                    amp_im[i0] = rnd_sat(m[0]*ai + m[1]*ar + m[2]*bi + m[3]*br);
                    amp_re[i1] = rnd_sat(m[4]*ar - m[5]*ai + m[6]*br - m[7]*bi);
                    amp_im[i1] = rnd_sat(m[4]*ai + m[5]*ar + m[6]*bi + m[7]*br);
                end
            end
            push_res(KIND_GATE, 0, 0, 1);
        end else if (fn == F_CNOT) begin
            if (cq >= n || tq >= n || cq == tq) begin
                push_res(KIND_IGNORE, 0, 0, 1); return;
            end
            for (int i = 0; i < dim; i++)
                if (i[cq] && !i[tq]) begin
                    i1 = i ^ (1 << tq);
                    t = amp_re[i]; amp_re[i] = amp_re[i1]; amp_re[i1] = t;
                    t = amp_im[i]; amp_im[i] = amp_im[i1]; amp_im[i1] = t;
                end
            push_res(KIND_GATE, 0, 0, 1);
        end else if (fn == F_READ) begin
            if (off > dim) off = dim;
            if (cnt > MAX_READ) cnt = MAX_READ;
            if (cnt > dim - off) cnt = dim - off;
            if (cnt == 0) begin push_res(KIND_IGNORE, 0, 0, 1); return; end
            for (int i = 0; i < cnt; i++)
                push_res(KIND_PROB, prob_of(power_at(off + i)), off + i, i + 1 == cnt);
        end else if (fn == F_SAMPLE) begin
            acc = 0; thr = longint'(r) << 16; pick = dim - 1;
            for (int i = 0; i < dim; i++) begin
                acc += power_at(i);
                if (thr < acc) begin pick = i; break; end
            end
            push_res(KIND_SAMPLE, prob_of(power_at(pick)), pick, 1);
        end else begin
            push_res(KIND_IGNORE, 0, 0, 1);
        end
    endfunction

    // sender idles in bursts; valid drops only at a gap or a drain
    task automatic send_command(logic [3:0] fn, logic [3:0] tq, logic [3:0] cq,
                                logic [17:0] ang, logic [9:0] off, logic [6:0] cnt,
                                logic [15:0] r);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            if ($urandom_range(0, 2) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_func <= fn; i_target_qubit <= tq; i_control_qubit <= cq; i_angle <= ang;
        i_read_offset <= off; i_read_count <= cnt; i_uniform_draw <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_command(fn, tq, cq, ang, off, cnt, r);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_qubit_count(logic [3:0] v);
        drain();
        i_cfg_valid <= 1'b1; i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        nq = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_command(int n);
        logic [3:0] fn;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4) fn = 4'($urandom_range(9, 15));
        else if (pick < 8) fn = F_RESET;
        else if (pick < 20) fn = F_READ;
        else if (pick < 32) fn = F_SAMPLE;
        else fn = 4'($urandom_range(1, 6));
        send_command(fn,
            ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, n - 1)),
            ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, n - 1)),
            18'($urandom),
            ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 1 << n)),
            ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 64)),
            16'($urandom));
    endtask

    task automatic test_directed();
        send_command(F_READ, 0, 0, 0, 0, 1, 0);
        send_command(F_H, 0, 0, 0, 0, 0, 0);
        send_command(F_CNOT, 1, 0, 0, 0, 0, 0);
        send_command(F_CNOT, 3, 3, 0, 0, 0, 0);
        send_command(F_CNOT, 15, 0, 0, 0, 0, 0);
        send_command(F_X, 9, 0, 0, 0, 0, 0);
        send_command(F_H, 15, 0, 0, 0, 0, 0);
        send_command(F_RX, 2, 0, 18'h3FFFF, 0, 0, 0);
        send_command(F_RY, 3, 0, 18'h10000, 0, 0, 0);
        send_command(F_RZ, 0, 0, 18'h2ABCD, 0, 0, 0);
        send_command(F_RY, 1, 0, 18'h0, 0, 0, 0);
        send_command(F_READ, 0, 0, 0, 0, 64, 0);
        send_command(F_READ, 0, 0, 0, 10'h3FF, 7'h7F, 0);
        send_command(F_READ, 0, 0, 0, 10'h3F0, 64, 0);
        send_command(F_READ, 0, 0, 0, 5, 0, 0);
        send_command(F_SAMPLE, 0, 0, 0, 0, 0, 16'h0000);
        send_command(F_SAMPLE, 0, 0, 0, 0, 0, 16'hFFFF);
        send_command(F_SAMPLE, 0, 0, 0, 0, 0, 16'h8000);
        send_command(4'd9, 0, 0, 0, 0, 0, 0);
        send_command(4'd15, 4'hF, 4'hF, 18'h3FFFF, 10'h3FF, 7'h7F, 16'hFFFF);
        send_command(F_RESET, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_random_at(int n, int count);
        write_qubit_count(4'(n));
        send_command(F_RESET, 0, 0, 0, 0, 0, 0);
        repeat (count) random_command(n);
    endtask

    task automatic test_backpressure();
        hold_cycles = 3000;
        repeat (6) send_command(F_READ, 0, 0, 0, 0, 64, 0);
    endtask

    task automatic test_odd_counts();
        write_qubit_count(4'd0);
        send_command(F_H, 0, 0, 0, 0, 0, 0);
        send_command(F_READ, 0, 0, 0, 0, 64, 0);
        write_qubit_count(4'd15);
        send_command(F_READ, 0, 0, 0, 10'h3FF, 64, 0);
        send_command(F_SAMPLE, 0, 0, 0, 0, 0, 16'h7FFF);
    endtask

    initial begin
        nq = 10;
        clear_amplitudes();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        stall_mode = 1;
        test_directed();
        stall_mode = 0;
        test_random_at(4, 150);
        stall_mode = 2;
        test_random_at(1, 60);
        stall_mode = 1;
        test_random_at(3, 150);
        test_backpressure();
        test_random_at(10, 30);
        test_odd_counts();
        test_random_at(6, 60);
        drain();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
